@@ design/bmm_pkg.sv @@
package bmm_pkg;

  localparam int VW         = 6;
  localparam int MAX_LEFT   = 32;
  localparam int MAX_RIGHT  = 32;
  localparam int MAX_DEGREE = 32;
  localparam int LW         = $clog2(MAX_LEFT);
  localparam int KW         = $clog2(MAX_DEGREE);
  localparam int NB_AW      = LW + KW;
  localparam int NB_DEPTH   = MAX_LEFT * MAX_DEGREE;
  localparam int STK_DEPTH  = MAX_LEFT;
  localparam int CFG_IW     = 1;

  localparam logic [VW-1:0] FAR_LAYER = '1;
  localparam logic [VW-1:0] LEFT_MAX  = VW'(MAX_LEFT);
  localparam logic [VW-1:0] RIGHT_MAX = VW'(MAX_RIGHT);
  localparam logic [VW-1:0] DEG_MAX   = VW'(MAX_DEGREE);

  localparam logic [CFG_IW-1:0] CFG_LEFT_COUNT  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_RIGHT_COUNT = 1'b1;

  // controller states, also the command to the datapath
  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_BINIT = 4'd1;
  localparam logic [3:0] OP_BPOP  = 4'd2;
  localparam logic [3:0] OP_BEDGE = 4'd3;
  localparam logic [3:0] OP_BV    = 4'd4;
  localparam logic [3:0] OP_BW    = 4'd5;
  localparam logic [3:0] OP_ASCAN = 4'd6;
  localparam logic [3:0] OP_ATOP  = 4'd7;
  localparam logic [3:0] OP_AV    = 4'd8;
  localparam logic [3:0] OP_AW    = 4'd9;
  localparam logic [3:0] OP_AFLIP = 4'd10;
  localparam logic [3:0] OP_EMIT  = 4'd11;
  localparam logic [3:0] OP_CLEAR = 4'd12;

  typedef struct packed {
    logic [3:0] op;
  } bmm_cmd_t;

  typedef struct packed {
    logic edge_last;
    logic idx_last;
    logic idx_over;
    logic head_lt_tail;
    logic bfs_skip;
    logic dist0_far;
    logic k_lt_deg;
    logic v_ok;
    logic aug_ok;
    logic w_zero;
    logic left_free;
    logic stack_empty;
    logic out_free;
  } bmm_status_t;

  function automatic logic [VW-1:0] clamp_count(logic [VW-1:0] v, logic [VW-1:0] maxv);
    logic [VW-1:0] r;
    if (v == '0) r = VW'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

@@ design/bmm_edge_if.sv @@
interface bmm_edge_if import bmm_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [VW-1:0] left_vertex;
  logic [VW-1:0] right_vertex;
  logic          last_edge;

  modport source (output valid, left_vertex, right_vertex, last_edge, input ready);
  modport sink   (input valid, left_vertex, right_vertex, last_edge, output ready);
endinterface

@@ design/bmm_res_if.sv @@
interface bmm_res_if import bmm_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [VW-1:0] out_left;
  logic [VW-1:0] partner;
  logic [VW-1:0] matching_size;
  logic          edge_dropped;
  logic          last_result;

  modport source (output valid, out_left, partner, matching_size, edge_dropped, last_result,
                  input ready);
  modport sink   (input valid, out_left, partner, matching_size, edge_dropped, last_result,
                  output ready);
endinterface

@@ design/bmm_ctrl.sv @@
module bmm_ctrl import bmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  bmm_status_t st,
  output bmm_cmd_t    cmd
);

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      OP_LOAD:  if (st.edge_last) state_nxt = OP_BINIT;
      OP_BINIT: if (st.idx_last) state_nxt = OP_BPOP;
      OP_BPOP: begin
        if (st.head_lt_tail) state_nxt = st.bfs_skip ? OP_BPOP : OP_BEDGE;
        else state_nxt = st.dist0_far ? OP_EMIT : OP_ASCAN;
      end
      OP_BEDGE: state_nxt = st.k_lt_deg ? OP_BV : OP_BPOP;
      OP_BV:    state_nxt = st.v_ok ? OP_BW : OP_BEDGE;
      OP_BW:    state_nxt = OP_BEDGE;
      OP_ASCAN: begin
        if (st.idx_over) state_nxt = OP_BINIT;
        else if (st.left_free) state_nxt = OP_ATOP;
      end
      OP_ATOP: begin
        if (st.k_lt_deg) state_nxt = OP_AV;
        else if (st.stack_empty) state_nxt = OP_ASCAN;
      end
      OP_AV:    state_nxt = st.v_ok ? OP_AW : OP_ATOP;
      OP_AW:    state_nxt = (st.aug_ok && st.w_zero) ? OP_AFLIP : OP_ATOP;
      OP_AFLIP: if (st.stack_empty) state_nxt = OP_ASCAN;
      OP_EMIT:  if (st.out_free && st.idx_last) state_nxt = OP_CLEAR;
      OP_CLEAR: state_nxt = OP_LOAD;
      default:  state_nxt = OP_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= OP_LOAD;
    else state_r <= state_nxt;
  end

  assign cmd.op = state_r;

  a_clear_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == OP_CLEAR) |=> (state_r == OP_LOAD))
    else $error("clear not followed by load");
  a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == OP_EMIT && $past(state_r) != OP_EMIT) |-> ($past(state_r) == OP_BPOP))
    else $error("emit entered from outside layering");
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == OP_BINIT && $past(state_r) != OP_BINIT) |->
      ($past(state_r) == OP_LOAD || $past(state_r) == OP_ASCAN))
    else $error("layering entered from bad state");

endmodule

@@ design/bmm_dpath.sv @@
module bmm_dpath import bmm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  bmm_cmd_t          cmd,
  output bmm_status_t       st,
  bmm_edge_if.sink          in_edge,
  bmm_res_if.source         out_res,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [VW-1:0]     cfg_data
);

  // configuration
  logic [VW-1:0] left_count_r, right_count_r, n_c, m_c;

  // stores
  logic [VW-1:0] nb_mem [NB_DEPTH];
  logic [VW-1:0] deg_r  [MAX_LEFT];
  logic [VW-1:0] mol_r  [MAX_LEFT];
  logic [VW-1:0] mor_r  [MAX_RIGHT];
  logic [VW-1:0] dist_r [MAX_LEFT];
  logic [VW-1:0] queue_r[MAX_LEFT];
  logic [VW-1:0] stk_u_r[STK_DEPTH];
  logic [VW-1:0] stk_k_r[STK_DEPTH];
  logic [VW-1:0] stk_d_r[STK_DEPTH];
  logic [VW-1:0] stk_v_r[STK_DEPTH];

  logic [VW-1:0] dist0_r, head_r, tail_r, depth_r, idx_r, size_r;
  logic [VW-1:0] cur_u_r, cur_k_r, du_r, v_r, w_r, mem_q_r;
  logic          drop_r;
  logic          out_valid_r, out_last_r, out_drop_r;
  logic [VW-1:0] out_left_r, out_partner_r, out_size_r;

  logic [LW-1:0] cu_i, idx_i, v_i, w_i, mq_i, lv_i, qu_i, pop_i, push_i, head_i, tail_i;
  logic [VW-1:0] lv, rv, deg_cu, q_u, distw, du_inc;
  logic          in_fire, edge_ok, out_free, w_ok, left_free;
  logic [NB_AW-1:0] wr_addr, rd_addr;

  assign n_c = clamp_count(left_count_r, LEFT_MAX);
  assign m_c = clamp_count(right_count_r, RIGHT_MAX);

  assign lv   = in_edge.left_vertex;
  assign rv   = in_edge.right_vertex;
  assign lv_i = LW'(lv - VW'(1));
  assign cu_i = LW'(cur_u_r - VW'(1));
  assign idx_i = LW'(idx_r - VW'(1));
  assign v_i  = LW'(v_r - VW'(1));
  assign w_i  = LW'(w_r - VW'(1));
  assign mq_i = LW'(mem_q_r - VW'(1));
  assign head_i = head_r[LW-1:0];
  assign tail_i = tail_r[LW-1:0];
  assign push_i = depth_r[LW-1:0];
  assign pop_i  = LW'(depth_r - VW'(1));
  assign q_u  = queue_r[head_i];
  assign qu_i = LW'(q_u - VW'(1));

  assign in_edge.ready = (cmd.op == OP_LOAD);
  assign in_fire = in_edge.valid && in_edge.ready;
  assign edge_ok = (lv != '0) && (lv <= n_c) && (rv != '0) && (rv <= m_c) &&
                   (deg_r[lv_i] < DEG_MAX);
  assign wr_addr = {lv_i, deg_r[lv_i][KW-1:0]};
  assign rd_addr = {cu_i, cur_k_r[KW-1:0]};

  assign deg_cu    = deg_r[cu_i];
  assign distw     = (w_r == '0) ? dist0_r : dist_r[w_i];
  assign du_inc    = du_r + VW'(1);
  assign w_ok      = (w_r <= n_c);
  assign left_free = (mol_r[idx_i] == '0);
  assign out_free  = !out_valid_r || out_res.ready;

  assign st.edge_last    = in_fire && in_edge.last_edge;
  assign st.idx_last     = (idx_r == n_c);
  assign st.idx_over     = (idx_r > n_c);
  assign st.head_lt_tail = (head_r < tail_r);
  assign st.bfs_skip     = (dist_r[qu_i] >= dist0_r);
  assign st.dist0_far    = (dist0_r == FAR_LAYER);
  assign st.k_lt_deg     = (cur_k_r < deg_cu);
  assign st.v_ok         = (mem_q_r != '0) && (mem_q_r <= m_c);
  assign st.aug_ok       = w_ok && (du_r != FAR_LAYER) && (distw == du_inc);
  assign st.w_zero       = (w_r == '0);
  assign st.left_free    = left_free;
  assign st.stack_empty  = (depth_r == '0);
  assign st.out_free     = out_free;

  // neighbour memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && in_fire && edge_ok) nb_mem[wr_addr] <= rv;
    if (cmd.op == OP_BEDGE || cmd.op == OP_ATOP) mem_q_r <= nb_mem[rd_addr];
  end

  // control state and stores with a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_count_r  <= LEFT_MAX;
      right_count_r <= RIGHT_MAX;
      for (int i = 0; i < MAX_LEFT; i++) begin
        deg_r[i] <= '0;
        mol_r[i] <= '0;
      end
      for (int i = 0; i < MAX_RIGHT; i++) mor_r[i] <= '0;
      drop_r <= 1'b0;
      size_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      depth_r <= '0;
      idx_r <= VW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LEFT_COUNT) left_count_r <= cfg_data;
        else right_count_r <= cfg_data;
      end
      if (out_res.ready && cmd.op != OP_EMIT) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          if (in_fire) begin
            if (edge_ok) deg_r[lv_i] <= deg_r[lv_i] + VW'(1);
            else drop_r <= 1'b1;
            if (in_edge.last_edge) begin
              idx_r  <= VW'(1);
              head_r <= '0;
              tail_r <= '0;
            end
          end
        end
        OP_BINIT: begin
          if (left_free) tail_r <= tail_r + VW'(1);
          idx_r <= idx_r + VW'(1);
        end
        OP_BPOP: begin
          if (head_r < tail_r) head_r <= head_r + VW'(1);
          else idx_r <= VW'(1);
        end
        OP_BW: begin
          if (w_ok && distw == FAR_LAYER && w_r != '0 && tail_r < LEFT_MAX)
            tail_r <= tail_r + VW'(1);
        end
        OP_ASCAN: begin
          if (idx_r > n_c) begin
            idx_r  <= VW'(1);
            head_r <= '0;
            tail_r <= '0;
          end else if (left_free) depth_r <= '0;
          else idx_r <= idx_r + VW'(1);
        end
        OP_ATOP: begin
          if (!st.k_lt_deg) begin
            if (depth_r == '0) idx_r <= idx_r + VW'(1);
            else depth_r <= depth_r - VW'(1);
          end
        end
        OP_AW: begin
          if (st.aug_ok) begin
            if (w_r == '0) begin
              mol_r[cu_i] <= v_r;
              mor_r[v_i]  <= cur_u_r;
              size_r <= size_r + VW'(1);
            end else if (depth_r < VW'(STK_DEPTH)) depth_r <= depth_r + VW'(1);
          end
        end
        OP_AFLIP: begin
          if (depth_r == '0) idx_r <= idx_r + VW'(1);
          else begin
            mol_r[LW'(stk_u_r[pop_i] - VW'(1))] <= stk_v_r[pop_i];
            mor_r[LW'(stk_v_r[pop_i] - VW'(1))] <= stk_u_r[pop_i];
            depth_r <= depth_r - VW'(1);
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            idx_r <= idx_r + VW'(1);
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < MAX_LEFT; i++) begin
            deg_r[i] <= '0;
            mol_r[i] <= '0;
          end
          for (int i = 0; i < MAX_RIGHT; i++) mor_r[i] <= '0;
          drop_r <= 1'b0;
          size_r <= '0;
          idx_r  <= VW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: if (in_fire && in_edge.last_edge) dist0_r <= FAR_LAYER;
      OP_BINIT: begin
        if (left_free) begin
          dist_r[idx_i]  <= '0;
          queue_r[tail_i] <= idx_r;
        end else dist_r[idx_i] <= FAR_LAYER;
      end
      OP_BPOP: begin
        cur_u_r <= q_u;
        cur_k_r <= '0;
        du_r    <= dist_r[qu_i];
      end
      OP_BEDGE: if (st.k_lt_deg) cur_k_r <= cur_k_r + VW'(1);
      OP_BV, OP_AV: begin
        v_r <= mem_q_r;
        w_r <= mor_r[mq_i];
      end
      OP_BW: begin
        if (w_ok && distw == FAR_LAYER) begin
          if (w_r == '0) dist0_r <= du_inc;
          else begin
            dist_r[w_i] <= du_inc;
            if (tail_r < LEFT_MAX) queue_r[tail_i] <= w_r;
          end
        end
      end
      OP_ASCAN: begin
        if (idx_r > n_c) dist0_r <= FAR_LAYER;
        else begin
          cur_u_r <= idx_r;
          cur_k_r <= '0;
          du_r    <= dist_r[idx_i];
        end
      end
      OP_ATOP: begin
        if (st.k_lt_deg) cur_k_r <= cur_k_r + VW'(1);
        else begin
          dist_r[cu_i] <= FAR_LAYER;
          if (depth_r != '0) begin
            cur_u_r <= stk_u_r[pop_i];
            cur_k_r <= stk_k_r[pop_i];
            du_r    <= stk_d_r[pop_i];
          end
        end
      end
      OP_AW: begin
        if (st.aug_ok && w_r != '0 && depth_r < VW'(STK_DEPTH)) begin
          stk_u_r[push_i] <= cur_u_r;
          stk_k_r[push_i] <= cur_k_r;
          stk_d_r[push_i] <= du_r;
          stk_v_r[push_i] <= v_r;
          cur_u_r <= w_r;
          cur_k_r <= '0;
          du_r    <= du_inc;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_left_r    <= idx_r;
          out_partner_r <= mol_r[idx_i];
          out_size_r    <= size_r;
          out_drop_r    <= drop_r;
          out_last_r    <= (idx_r == n_c);
        end
      end
      default: ;
    endcase
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.out_left      = out_left_r;
  assign out_res.partner       = out_partner_r;
  assign out_res.matching_size = out_size_r;
  assign out_res.edge_dropped  = out_drop_r;
  assign out_res.last_result   = out_last_r;

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n) head_r <= tail_r)
    else $error("queue head passed tail");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= VW'(STK_DEPTH))
    else $error("stack overflow");
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n) size_r <= LEFT_MAX)
    else $error("matching size above left vertex count");
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_CLEAR) |=> (size_r == '0 && !drop_r))
    else $error("stores not cleared after run");

endmodule

@@ design/bipartite_max_matching.sv @@
// channel   | dir | beat payload                                  | handshake
// in_edge   | in  | left_vertex, right_vertex, last_edge          | valid/ready
// out_res   | out | out_left, partner, matching_size,             | valid/ready
//           |     | edge_dropped, last_result                     |
// cfg       | in  | cfg_index, cfg_data                           | cfg_we, no wait
//
// edges load one beat per cycle while the controller sits in load
// a last edge starts the matching run: neighbour visits in each layering and augmenting
//   phase are bound by the single neighbour memory read port,
//   then one result beat per left vertex and a clear step for the stores
// reset is synchronous, active low; counts return to 32, no clearing pass needed
// a stalled result holds in the output register; the run halts until it is taken
module bipartite_max_matching import bmm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bmm_edge_if.sink          in_edge,
  bmm_res_if.source         out_res,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [VW-1:0]     cfg_data
);

  bmm_cmd_t    cmd;
  bmm_status_t st;

  // sequencer for load, layering, augmenting, result and clear steps
  bmm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  // stores, neighbour memory, search queue and stack, result register
  bmm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_edge   (in_edge),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ bench/bipartite_max_matching_tb.sv @@
module bipartite_max_matching_tb;
  import bmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned UNREACHED = 32'hFFFF_FFFF;

  // one result beat as the block should present it
  typedef struct {
    logic [VW-1:0] left_id;
    logic [VW-1:0] partner;
    logic [VW-1:0] pairs;
    logic          dropped;
    logic          final_left;
  } match_row_t;

  // matching predictor and store of expected result beats
  class match_scoreboard;
    byte unsigned adj[MAX_LEFT+1][MAX_DEGREE];
    int unsigned  deg[MAX_LEFT+1];
    int unsigned  mate_l[MAX_LEFT+1];
    int unsigned  mate_r[MAX_RIGHT+1];
    int unsigned  layer_of[MAX_LEFT+1];
    bit           dropped;
    int unsigned  left_reg = 32;
    int unsigned  right_reg = 32;
    match_row_t   pending_rows[$];
    int           errors;
    int           rows_seen;
    int           runs;

    function void clear_graph();
      foreach (deg[i]) deg[i] = 0;
      foreach (mate_l[i]) mate_l[i] = 0;
      foreach (mate_r[i]) mate_r[i] = 0;
      dropped = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned top);
      return (v == 0) ? 1 : (v > top) ? top : v;
    endfunction

    // breadth-first layering from the free left vertices
    function bit layer_graph(int unsigned n, int unsigned m);
      int unsigned fifo[MAX_LEFT+2];
      int unsigned head, tail, u, v, w;
      head = 0;
      tail = 0;
      for (u = 1; u <= n; u++) begin
        if (mate_l[u] == 0) begin
          layer_of[u] = 0;
          fifo[tail++] = u;
        end else begin
          layer_of[u] = UNREACHED;
        end
      end
      layer_of[0] = UNREACHED;
      while (head < tail) begin
        u = fifo[head++];
        if (layer_of[u] >= layer_of[0]) continue;
        for (int k = 0; k < deg[u]; k++) begin
          v = adj[u][k];
          if (v < 1 || v > m) continue;
          w = mate_r[v];
          if (w > n) continue;
          if (layer_of[w] == UNREACHED) begin
            layer_of[w] = layer_of[u] + 1;
            if (w != 0 && tail <= MAX_LEFT) fifo[tail++] = w;
          end
        end
      end
      return layer_of[0] != UNREACHED;
    endfunction

    // depth-first augmenting search along the layers, explicit stack
    function bit augment(int unsigned root, int unsigned n, int unsigned m);
      int unsigned sv[MAX_LEFT+1];
      int unsigned sn[MAX_LEFT+1];
      int unsigned sp, u, v, w, a, b;
      sp = 1;
      sv[0] = root;
      sn[0] = 0;
      while (sp > 0) begin
        u = sv[sp-1];
        if (sn[sp-1] < deg[u]) begin
          v = adj[u][sn[sp-1]];
          sn[sp-1]++;
          if (v < 1 || v > m) continue;
          w = mate_r[v];
          if (w > n) continue;
          if (layer_of[u] == UNREACHED) continue;
          if (layer_of[w] != layer_of[u] + 1) continue;
          if (w == 0) begin
            for (int unsigned f = sp; f > 0; f--) begin
              a = sv[f-1];
              b = adj[a][sn[f-1]-1];
              mate_l[a] = b;
              mate_r[b] = a;
            end
            return 1;
          end
          if (sp <= MAX_LEFT) begin
            sv[sp] = w;
            sn[sp] = 0;
            sp++;
          end
        end else begin
          layer_of[u] = UNREACHED;
          sp--;
        end
      end
      return 0;
    endfunction

    function void note_edge(logic [VW-1:0] lv, logic [VW-1:0] rv, logic last);
      int unsigned n, m, size;
      match_row_t row;
      n = clamp(left_reg, MAX_LEFT);
      m = clamp(right_reg, MAX_RIGHT);
      size = 0;
      if (lv >= 1 && lv <= n && rv >= 1 && rv <= m && deg[lv] < MAX_DEGREE) begin
        adj[lv][deg[lv]] = rv;
        deg[lv]++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      while (layer_graph(n, m))
        for (int unsigned i = 1; i <= n; i++)
          if (mate_l[i] == 0 && augment(i, n, m)) size++;
      for (int unsigned i = 1; i <= n; i++) begin
        row.left_id    = VW'(i);
        row.partner    = VW'(mate_l[i]);
        row.pairs      = VW'(size);
        row.dropped    = dropped;
        row.final_left = (i == n);
        pending_rows.insert(pending_rows.size(), row);
      end
      runs++;
      clear_graph();
    endfunction

    function void check_row(match_row_t got);
      match_row_t want;
      rows_seen++;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected result beat left=%0d partner=%0d", $time,
                 got.left_id, got.partner);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      if (got.left_id != want.left_id || got.partner != want.partner ||
          got.pairs != want.pairs || got.dropped != want.dropped ||
          got.final_left != want.final_left) begin
        $display("%0t: mismatch exp left=%0d partner=%0d size=%0d drop=%0b last=%0b",
                 $time, want.left_id, want.partner, want.pairs, want.dropped,
                 want.final_left);
        $display("%0t:          act left=%0d partner=%0d size=%0d drop=%0b last=%0b",
                 $time, got.left_id, got.partner, got.pairs, got.dropped,
                 got.final_left);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [VW-1:0]     cfg_data = '0;

  bmm_edge_if edge_ch ();
  bmm_res_if  res_ch ();

  bipartite_max_matching dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_edge   (edge_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  match_scoreboard sb = new();
  int  edges_sent;
  bit  steady_src;   // no gaps on the edge side for this graph
  bit  steady_sink;  // no stalls on the result side for this graph
  int  stall_left;

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, driven at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (steady_sink) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      res_ch.ready <= (stall_left == 0);
    end
  end

  // result beats taken at the rising edge go straight to the checker
  always @(posedge clk) begin
    match_row_t got;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.left_id    = res_ch.out_left;
      got.partner    = res_ch.partner;
      got.pairs      = res_ch.matching_size;
      got.dropped    = res_ch.edge_dropped;
      got.final_left = res_ch.last_result;
      sb.check_row(got);
    end
  end

  // one edge beat, with a random gap ahead of it
  task automatic send_edge(int lv, int rv, bit last);
    int g;
    g = steady_src ? 0 : pick_gap();
    if (g > 0) begin
      @(negedge clk);
      edge_ch.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    edge_ch.valid        <= 1'b1;
    edge_ch.left_vertex  <= VW'(lv);
    edge_ch.right_vertex <= VW'(rv);
    edge_ch.last_edge    <= last;
    do @(posedge clk); while (!edge_ch.ready);
    sb.note_edge(VW'(lv), VW'(rv), last);
    edges_sent++;
  endtask

  // let every result drain, then allow the clear step to pass
  task automatic wait_idle();
    @(negedge clk);
    edge_ch.valid <= 1'b0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= VW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LEFT_COUNT) sb.left_reg = val & 6'h3f;
    else sb.right_reg = val & 6'h3f;
  endtask

  function automatic int pick_count();
    int p;
    p = $urandom_range(9);
    case (p)
      0: return 1;
      1: return 32;
      2: return 0;
      3: return 63;
      default: return $urandom_range(1, 32);
    endcase
  endfunction

  // random vertex, mostly in range, sometimes anything the field allows
  function automatic int pick_vertex(int cnt);
    if ($urandom_range(99) < 92) return $urandom_range(1, cnt);
    return $urandom_range(0, 63);
  endfunction

  initial begin
    int n, m, ne, hot, graphs;
    edge_ch.valid        = 1'b0;
    edge_ch.left_vertex  = '0;
    edge_ch.right_vertex = '0;
    edge_ch.last_edge    = 1'b0;
    steady_src  = 0;
    steady_sink = 0;
    stall_left  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: a path that needs one augmentation
    send_edge(1, 1, 0);
    send_edge(1, 2, 0);
    send_edge(2, 1, 1);
    wait_idle();
    // corners of the vertex range, plus edges out of range
    send_edge(1, 32, 0);
    send_edge(32, 1, 0);
    send_edge(32, 32, 0);
    send_edge(0, 5, 0);
    send_edge(5, 0, 0);
    send_edge(33, 1, 0);
    send_edge(63, 63, 1);
    wait_idle();
    // empty graph whose last edge is itself dropped
    send_edge(0, 0, 1);
    wait_idle();
    // single vertex on each side, duplicate edge included
    write_reg(CFG_LEFT_COUNT, 1);
    write_reg(CFG_RIGHT_COUNT, 1);
    send_edge(1, 1, 0);
    send_edge(2, 1, 0);
    send_edge(1, 1, 0);
    send_edge(1, 2, 1);
    wait_idle();
    // zero counts act as one, oversized counts as the maximum
    write_reg(CFG_LEFT_COUNT, 0);
    write_reg(CFG_RIGHT_COUNT, 0);
    send_edge(1, 1, 1);
    wait_idle();
    write_reg(CFG_LEFT_COUNT, 63);
    write_reg(CFG_RIGHT_COUNT, 63);
    send_edge(32, 32, 1);
    wait_idle();

    // random graphs
    graphs = 0;
    while (edges_sent < 330) begin
      if (graphs % 3 == 0) begin
        write_reg(CFG_LEFT_COUNT, pick_count());
        write_reg(CFG_RIGHT_COUNT, pick_count());
      end
      n = sb.clamp(sb.left_reg, MAX_LEFT);
      m = sb.clamp(sb.right_reg, MAX_RIGHT);
      steady_src  = ($urandom_range(3) == 0);
      steady_sink = ($urandom_range(3) == 0);
      if (graphs == 4 || $urandom_range(19) == 0) begin
        // one left vertex pushed past its degree bound
        hot = $urandom_range(1, n);
        ne  = $urandom_range(MAX_DEGREE + 1, MAX_DEGREE + 6);
        for (int i = 0; i < ne; i++)
          send_edge(hot, $urandom_range(1, m), i == ne - 1);
      end else begin
        ne = ($urandom_range(3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < ne; i++)
          send_edge(pick_vertex(n), pick_vertex(m), i == ne - 1);
      end
      wait_idle();
      graphs++;
    end
    steady_sink = 0;
    wait_idle();
    repeat (50) @(posedge clk);

    $display("covered %0d edge beats over %0d matching runs, %0d result beats checked",
             edges_sent, sb.runs, sb.rows_seen);
    $display("counts from one to the maximum, out-of-range counts and dropped edges included");
    if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
      $display("** bipartite_max_matching: PASSED **");
    end else begin
      $display("** bipartite_max_matching: FAILED **");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("timeout waiting for the block");
    $display("** bipartite_max_matching: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
design/bmm_pkg.sv
design/bmm_edge_if.sv
design/bmm_res_if.sv
design/bmm_ctrl.sv
design/bmm_dpath.sv
design/bipartite_max_matching.sv
bench/bipartite_max_matching_tb.sv
